### rtl/svf_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and codes of the digit-serial state-variable filter
package svf_pkg;

  // default sizes of the channel set and the sample
  localparam int NUM_CHANNELS = 2;
  localparam int SAMPLE_BITS  = 24;

  // fixed formats
  localparam int COEF_BITS  = 24;
  localparam int MODE_BITS  = 2;
  localparam int STATE_BITS = 32;
  localparam int FRAC_BITS  = 22;

  // serial word: holds v1, v2, the new states and the high-pass sum
  localparam int DIGIT_BITS  = 2;
  localparam int WORD_BITS   = 40;
  localparam int PROD_BITS   = WORD_BITS + FRAC_BITS;
  localparam int PASS_DIGITS = PROD_BITS / DIGIT_BITS;
  localparam int SKIP_DIGITS = FRAC_BITS / DIGIT_BITS;
  localparam int WORD_DIGITS = WORD_BITS / DIGIT_BITS;
  localparam int STEP_BITS   = $clog2(PASS_DIGITS);

  // half an lsb of the rounded product, preloaded into the multiplier
  localparam logic [COEF_BITS:0] ROUND_INIT = (COEF_BITS + 1)'(2 ** (FRAC_BITS - 1));

  // configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_FILTER_MODE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A1     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A2     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A3     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DAMPING     = 3'd4;

  // register reset values
  localparam logic [COEF_BITS-1:0] COEF_A1_RESET = 24'd4194304;
  localparam logic [COEF_BITS-1:0] DAMPING_RESET = 24'd8388608;

  // response select codes
  localparam logic [MODE_BITS-1:0] MODE_LOW  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_HIGH = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_BAND = 2'd2;

  typedef logic [DIGIT_BITS-1:0] digit_t;
  typedef logic [STEP_BITS-1:0]  step_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS1,
    ST_PASS2,
    ST_DONE
  } seq_state_t;

  // sequencer controls for the datapath
  typedef struct packed {
    logic pass1;
    logic pass2;
    logic first;
    logic word;
    logic word_first;
    logic tail;
    logic finish;
  } seq_ctl_t;

endpackage

### rtl/svf_if.sv
`timescale 1ns / 1ps
// valid/ready channels for input samples and filtered results
interface svf_in_if #(
  parameter int SAMPLE_BITS = svf_pkg::SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic                          chan;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output chan, output sample_in, input ready);
  modport sink (input valid, input chan, input sample_in, output ready);
endinterface

interface svf_out_if #(
  parameter int SAMPLE_BITS = svf_pkg::SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic                          chan_out;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output chan_out, output sample_out, input ready);
  modport sink (input valid, input chan_out, input sample_out, output ready);
endinterface

### rtl/state_variable_filter_tpt_core.sv
`timescale 1ns / 1ps
// two-channel tpt state-variable filter, digit-serial datapath, top level
// a new item is accepted only in idle, once the last result is in the output register
// each item makes two passes of 31 two-bit digits through
//   the serial multipliers (the second pass reuses the a1 unit for damping*v1)
// the next item is taken while a finished result waits in the output register
// reset: synchronous, clears registers to their reset values and both integrators
module state_variable_filter_tpt_core #(
  parameter int NUM_CHANNELS = svf_pkg::NUM_CHANNELS,
  parameter int SAMPLE_BITS  = svf_pkg::SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  svf_in_if.sink                              sample_ch,
  svf_out_if.source                           result_ch,
  input  logic                                cfg_we,
  input  logic [svf_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [svf_pkg::COEF_BITS-1:0]       cfg_data
);
  localparam int D       = svf_pkg::DIGIT_BITS;
  localparam int W       = svf_pkg::WORD_BITS;
  localparam int SB      = svf_pkg::STATE_BITS;
  localparam int IdxBits = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // configuration
  logic [svf_pkg::MODE_BITS-1:0] mode_r;
  logic [svf_pkg::COEF_BITS-1:0] a1_r;
  logic [svf_pkg::COEF_BITS-1:0] a2_r;
  logic [svf_pkg::COEF_BITS-1:0] a3_r;
  logic [svf_pkg::COEF_BITS-1:0] damp_r;

  // integrator state
  logic signed [SB-1:0] integ_one [NUM_CHANNELS];
  logic signed [SB-1:0] integ_two [NUM_CHANNELS];

  // per-item registers
  logic                   chan_r;
  logic                   ok_r;
  logic [IdxBits-1:0]     idx_r;
  logic [SAMPLE_BITS-1:0] xs;
  logic [SAMPLE_BITS-1:0] xb;
  logic [SB-1:0]          i1s;
  logic [SB-1:0]          i2s;
  logic [SB-1:0]          i1b;
  logic [SB-1:0]          i2b;
  logic [W-1:0]           v1r;
  logic [W-1:0]           v2r;
  logic [W-1:0]           n1r;
  logic [W-1:0]           n2r;
  logic [W-1:0]           yr;
  logic                   v1_hi;
  logic                   v2_hi;

  // output register
  logic                   out_valid;
  logic                   out_chan;
  logic [SAMPLE_BITS-1:0] out_sample;

  svf_pkg::seq_ctl_t ctl;
  logic              ready;
  logic              accept;
  logic              out_free;
  logic              in_ok;
  logic [IdxBits-1:0] rd_idx;
  logic              word1;
  logic              word2;

  // digit streams
  svf_pkg::digit_t x_d, i1_d, i2_d, i1b_d, i2b_d, xb_d, v2r_d;
  svf_pkg::digit_t v3_d, m0_in, q0_d, q1_d, q2_d, q3_d;
  svf_pkg::digit_t v1_d, v2a_d, v2_d, dbl1_d, dbl2_d, n1_d, n2_d, ya_d, y_d;
  logic            v1_prev, v2_prev;
  logic [svf_pkg::COEF_BITS-1:0] m0_coef;

  // result selection and saturation
  logic [W-1:0]             y_sel;
  logic [W-SAMPLE_BITS:0]   y_top;
  logic [SAMPLE_BITS-1:0]   y_sat;
  logic [W-SB:0]            n1_top;
  logic [W-SB:0]            n2_top;
  logic [SB-1:0]            n1_sat;
  logic [SB-1:0]            n2_sat;

  assign accept    = sample_ch.valid && sample_ch.ready;
  assign out_free  = !out_valid || result_ch.ready;
  assign in_ok     = (int'(sample_ch.chan) < NUM_CHANNELS);
  assign rd_idx    = in_ok ? IdxBits'(sample_ch.chan) : '0;
  assign word1     = ctl.pass1 && ctl.word;
  assign word2     = ctl.pass2 && ctl.word;

  assign sample_ch.ready    = ready;
  assign result_ch.valid    = out_valid;
  assign result_ch.chan_out = out_chan;
  assign result_ch.sample_out = out_sample;

  svf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .out_free (out_free),
    .ready    (ready),
    .ctl      (ctl)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_r <= svf_pkg::MODE_LOW;
      a1_r   <= svf_pkg::COEF_A1_RESET;
      a2_r   <= '0;
      a3_r   <= '0;
      damp_r <= svf_pkg::DAMPING_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        svf_pkg::REG_FILTER_MODE: mode_r <= cfg_data[svf_pkg::MODE_BITS-1:0];
        svf_pkg::REG_COEF_A1:     a1_r   <= cfg_data;
        svf_pkg::REG_COEF_A2:     a2_r   <= cfg_data;
        svf_pkg::REG_COEF_A3:     a3_r   <= cfg_data;
        svf_pkg::REG_DAMPING:     damp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // digit taps of the shift registers
  assign x_d   = xs[D-1:0];
  assign xb_d  = xb[D-1:0];
  assign i1_d  = i1s[D-1:0];
  assign i2_d  = i2s[D-1:0];
  assign i1b_d = i1b[D-1:0];
  assign i2b_d = i2b[D-1:0];
  assign v2r_d = v2r[D-1:0];

  // v3 = x - ic2
  svf_digit_add u_v3 (
    .clk (clk), .en (ctl.pass1), .init (ctl.first), .sub (1'b1),
    .a (x_d), .b (i2_d), .sum (v3_d)
  );

  // shared unit: a1*ic1 in the first pass, damping*v1 in the second
  assign m0_coef = ctl.pass2 ? damp_r : a1_r;
  always_comb begin
    if (!ctl.pass2) begin
      m0_in = i1_d;
    end else if (ctl.tail) begin
      m0_in = {D{v1r[W-1]}};
    end else begin
      m0_in = v1r[D-1:0];
    end
  end

  svf_digit_mul u_mul_a1 (
    .clk (clk), .en (ctl.pass1 || ctl.pass2), .init (ctl.first),
    .coef (m0_coef), .din (m0_in), .dout (q0_d)
  );
  svf_digit_mul u_mul_a2v3 (
    .clk (clk), .en (ctl.pass1), .init (ctl.first),
    .coef (a2_r), .din (v3_d), .dout (q1_d)
  );
  svf_digit_mul u_mul_a2i1 (
    .clk (clk), .en (ctl.pass1), .init (ctl.first),
    .coef (a2_r), .din (i1_d), .dout (q2_d)
  );
  svf_digit_mul u_mul_a3v3 (
    .clk (clk), .en (ctl.pass1), .init (ctl.first),
    .coef (a3_r), .din (v3_d), .dout (q3_d)
  );

  // v1 = a1*ic1 + a2*v3
  svf_digit_add u_v1 (
    .clk (clk), .en (word1), .init (ctl.word_first), .sub (1'b0),
    .a (q0_d), .b (q1_d), .sum (v1_d)
  );

  // v2 = ic2 + a2*ic1 + a3*v3
  svf_digit_add u_v2a (
    .clk (clk), .en (word1), .init (ctl.word_first), .sub (1'b0),
    .a (i2b_d), .b (q2_d), .sum (v2a_d)
  );
  svf_digit_add u_v2 (
    .clk (clk), .en (word1), .init (ctl.word_first), .sub (1'b0),
    .a (v2a_d), .b (q3_d), .sum (v2_d)
  );

  // doubling is a one-bit delay of the stream
  assign v1_prev = ctl.word_first ? 1'b0 : v1_hi;
  assign v2_prev = ctl.word_first ? 1'b0 : v2_hi;
  assign dbl1_d  = D'({v1_d, v1_prev});
  assign dbl2_d  = D'({v2_d, v2_prev});

  // new integrators: 2*v - ic
  svf_digit_add u_n1 (
    .clk (clk), .en (word1), .init (ctl.word_first), .sub (1'b1),
    .a (dbl1_d), .b (i1b_d), .sum (n1_d)
  );
  svf_digit_add u_n2 (
    .clk (clk), .en (word1), .init (ctl.word_first), .sub (1'b1),
    .a (dbl2_d), .b (i2b_d), .sum (n2_d)
  );

  // high-pass: x - k*v1 - v2
  svf_digit_add u_ya (
    .clk (clk), .en (word2), .init (ctl.word_first), .sub (1'b1),
    .a (xb_d), .b (q0_d), .sum (ya_d)
  );
  svf_digit_add u_y (
    .clk (clk), .en (word2), .init (ctl.word_first), .sub (1'b1),
    .a (ya_d), .b (v2r_d), .sum (y_d)
  );

  // operand shift registers, loaded on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      chan_r <= sample_ch.chan;
      ok_r   <= in_ok;
      idx_r  <= rd_idx;
      xs     <= sample_ch.sample_in;
      xb     <= sample_ch.sample_in;
      i1s    <= integ_one[rd_idx];
      i1b    <= integ_one[rd_idx];
      i2s    <= integ_two[rd_idx];
      i2b    <= integ_two[rd_idx];
    end else begin
      if (ctl.pass1) begin
        xs  <= {{D{xs[SAMPLE_BITS-1]}}, xs[SAMPLE_BITS-1:D]};
        i1s <= {{D{i1s[SB-1]}}, i1s[SB-1:D]};
        i2s <= {{D{i2s[SB-1]}}, i2s[SB-1:D]};
      end
      if (word1) begin
        i1b <= {{D{i1b[SB-1]}}, i1b[SB-1:D]};
        i2b <= {{D{i2b[SB-1]}}, i2b[SB-1:D]};
      end
      if (word2) begin
        xb <= {{D{xb[SAMPLE_BITS-1]}}, xb[SAMPLE_BITS-1:D]};
      end
    end
  end

  // result words collected lsb first; v1 and v2 rotate back in place
  always_ff @(posedge clk) begin
    if (word1) begin
      v1r   <= {v1_d, v1r[W-1:D]};
      v2r   <= {v2_d, v2r[W-1:D]};
      n1r   <= {n1_d, n1r[W-1:D]};
      n2r   <= {n2_d, n2r[W-1:D]};
      v1_hi <= v1_d[D-1];
      v2_hi <= v2_d[D-1];
    end
    if (ctl.pass2 && !ctl.tail) begin
      v1r <= {v1r[D-1:0], v1r[W-1:D]};
    end
    if (word2) begin
      v2r <= {v2r[D-1:0], v2r[W-1:D]};
      yr  <= {y_d, yr[W-1:D]};
    end
  end

  // response select and saturation
  always_comb begin
    case (mode_r)
      svf_pkg::MODE_HIGH: y_sel = yr;
      svf_pkg::MODE_BAND: y_sel = v1r;
      default:            y_sel = v2r;
    endcase
  end

  assign y_top = y_sel[W-1:SAMPLE_BITS-1];
  assign y_sat = ((y_top == '0) || (y_top == '1)) ? y_sel[SAMPLE_BITS-1:0] :
                 (y_sel[W-1] ? {1'b1, {(SAMPLE_BITS - 1){1'b0}}} :
                               {1'b0, {(SAMPLE_BITS - 1){1'b1}}});

  assign n1_top = n1r[W-1:SB-1];
  assign n1_sat = ((n1_top == '0) || (n1_top == '1)) ? n1r[SB-1:0] :
                  (n1r[W-1] ? {1'b1, {(SB - 1){1'b0}}} : {1'b0, {(SB - 1){1'b1}}});
  assign n2_top = n2r[W-1:SB-1];
  assign n2_sat = ((n2_top == '0) || (n2_top == '1)) ? n2r[SB-1:0] :
                  (n2r[W-1] ? {1'b1, {(SB - 1){1'b0}}} : {1'b0, {(SB - 1){1'b1}}});

  // integrator write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        integ_one[i] <= '0;
        integ_two[i] <= '0;
      end
    end else if (ctl.finish && ok_r) begin
      integ_one[idx_r] <= n1_sat;
      integ_two[idx_r] <= n2_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_chan   <= chan_r;
      out_sample <= ok_r ? y_sat : '0;
    end
  end

  // checks
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !sample_ch.ready)
    else $error("new item taken while one is in flight");

  a_pass_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (ctl.pass1 && ctl.first))
    else $error("first pass did not start at digit zero");

  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |-> (!out_valid || result_ch.ready))
    else $error("result overwrote an item not yet taken");

  a_bad_chan: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (int'(out_chan) >= NUM_CHANNELS)) |-> (out_sample == '0))
    else $error("unknown channel gave a nonzero sample");

endmodule

### rtl/svf_digit_mul.sv
`timescale 1ns / 1ps
// serial-parallel multiplier: parallel coef, one value digit per cycle while enabled
module svf_digit_mul (
  input  logic                           clk,
  input  logic                           en,
  input  logic                           init,
  input  logic [svf_pkg::COEF_BITS-1:0]  coef,
  input  svf_pkg::digit_t                din,
  output svf_pkg::digit_t                dout
);
  localparam int AccBits = svf_pkg::COEF_BITS + 1;
  localparam int SumBits = AccBits + svf_pkg::DIGIT_BITS;

  logic [AccBits-1:0] acc;
  logic [AccBits-1:0] acc_cur;
  logic [SumBits-1:0] sum;

  // start from the rounding half lsb, then add coef times this digit
  assign acc_cur = init ? svf_pkg::ROUND_INIT : acc;
  assign sum     = SumBits'(acc_cur) + SumBits'(din) * SumBits'(coef);
  assign dout    = sum[svf_pkg::DIGIT_BITS-1:0];

  // carry the upper part into the next digit position
  always_ff @(posedge clk) begin
    if (en) begin
      acc <= sum[SumBits-1:svf_pkg::DIGIT_BITS];
    end
  end

endmodule

### rtl/svf_digit_add.sv
`timescale 1ns / 1ps
// digit-serial adder or subtractor with a stored carry
module svf_digit_add (
  input  logic            clk,
  input  logic            en,
  input  logic            init,
  input  logic            sub,
  input  svf_pkg::digit_t a,
  input  svf_pkg::digit_t b,
  output svf_pkg::digit_t sum
);
  localparam int D = svf_pkg::DIGIT_BITS;

  logic         carry;
  logic         cin;
  logic [D-1:0] b_eff;
  logic [D:0]   t;

  // subtract as a plus inverted b plus one
  assign cin   = init ? sub : carry;
  assign b_eff = sub ? ~b : b;
  assign t     = {1'b0, a} + {1'b0, b_eff} + (D + 1)'(cin);
  assign sum   = t[D-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      carry <= t[D];
    end
  end

endmodule

### rtl/svf_seq.sv
`timescale 1ns / 1ps
// sequencer: two multiply passes over the digit stream, then result handoff
module svf_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              out_free,
  output logic              ready,
  output svf_pkg::seq_ctl_t ctl
);
  localparam svf_pkg::step_t StepLast  = svf_pkg::step_t'(svf_pkg::PASS_DIGITS - 1);
  localparam svf_pkg::step_t StepSkip  = svf_pkg::step_t'(svf_pkg::SKIP_DIGITS);
  localparam svf_pkg::step_t StepWords = svf_pkg::step_t'(svf_pkg::WORD_DIGITS);

  svf_pkg::seq_state_t state;
  svf_pkg::seq_state_t state_next;
  svf_pkg::step_t      step;
  svf_pkg::step_t      step_next;
  logic                in_pass;

  assign in_pass = (state == svf_pkg::ST_PASS1) || (state == svf_pkg::ST_PASS2);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      svf_pkg::ST_IDLE: begin
        if (start) state_next = svf_pkg::ST_PASS1;
      end
      svf_pkg::ST_PASS1: begin
        if (step == StepLast) state_next = svf_pkg::ST_PASS2;
      end
      svf_pkg::ST_PASS2: begin
        if (step == StepLast) state_next = svf_pkg::ST_DONE;
      end
      svf_pkg::ST_DONE: begin
        if (out_free) state_next = svf_pkg::ST_IDLE;
      end
      default: state_next = svf_pkg::ST_IDLE;
    endcase
  end

  // digit step counter within a pass
  always_comb begin
    if (in_pass && (step != StepLast)) begin
      step_next = step + 1'b1;
    end else begin
      step_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svf_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // outputs
  always_comb begin
    ready          = (state == svf_pkg::ST_IDLE);
    ctl.pass1      = (state == svf_pkg::ST_PASS1);
    ctl.pass2      = (state == svf_pkg::ST_PASS2);
    ctl.first      = (step == '0);
    ctl.word       = (step >= StepSkip);
    ctl.word_first = (step == StepSkip);
    ctl.tail       = (step >= StepWords);
    ctl.finish     = (state == svf_pkg::ST_DONE) && out_free;
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the two-channel tpt state-variable filter core
module tb_top;

  localparam int SBITS = svf_pkg::SAMPLE_BITS;
  // mode code 3 is not in the package, the block treats it as low-pass
  localparam logic [svf_pkg::MODE_BITS-1:0] MODE_LOW_ALIAS = 2'd3;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic             chan;
    logic [SBITS-1:0] sample;
  } svf_sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                             cfg_we;
  logic [svf_pkg::CFG_IDX_BITS-1:0] cfg_idx;
  logic [svf_pkg::COEF_BITS-1:0]    cfg_data;

  svf_in_if  #(.SAMPLE_BITS(SBITS)) sample_if ();
  svf_out_if #(.SAMPLE_BITS(SBITS)) result_if ();

  state_variable_filter_tpt_core #(
    .NUM_CHANNELS(svf_pkg::NUM_CHANNELS),
    .SAMPLE_BITS (SBITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .sample_ch(sample_if),
    .result_ch(result_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // shadow registers and integrator state of the filter
  logic [svf_pkg::MODE_BITS-1:0] mode_r    = svf_pkg::MODE_LOW;
  logic [svf_pkg::COEF_BITS-1:0] a1_r      = svf_pkg::COEF_A1_RESET;
  logic [svf_pkg::COEF_BITS-1:0] a2_r      = '0;
  logic [svf_pkg::COEF_BITS-1:0] a3_r      = '0;
  logic [svf_pkg::COEF_BITS-1:0] damping_r = svf_pkg::DAMPING_RESET;
  int integ_one [svf_pkg::NUM_CHANNELS];
  int integ_two [svf_pkg::NUM_CHANNELS];

  svf_sample_t pending_q[$];
  svf_sample_t filtered_q[$];
  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  logic in_taken = 1'b0;

  initial forever #1 clk = ~clk;

  // coefficient times value, rounded half up to the value's lsb
  function automatic longint coef_mul(input logic [svf_pkg::COEF_BITS-1:0] coef,
                                      input longint v);
    longint c;
    c = coef;
    return (c * v + (64'sd1 <<< (svf_pkg::FRAC_BITS - 1))) >>> svf_pkg::FRAC_BITS;
  endfunction

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -(64'sd1 <<< (bits - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one filter step on a channel: updates the integrators, returns the selected response
  function automatic logic [SBITS-1:0] svf_filter_step(input logic ch,
                                                       input logic signed [SBITS-1:0] x_in);
    longint x, ic1, ic2, v1, v2, v3, y;
    x   = x_in;
    ic1 = integ_one[ch];
    ic2 = integ_two[ch];
    v3  = x - ic2;
    v1  = coef_mul(a1_r, ic1) + coef_mul(a2_r, v3);
    v2  = ic2 + coef_mul(a2_r, ic1) + coef_mul(a3_r, v3);
    integ_one[ch] = int'(clamp(2 * v1 - ic1, svf_pkg::STATE_BITS));
    integ_two[ch] = int'(clamp(2 * v2 - ic2, svf_pkg::STATE_BITS));
    case (mode_r)
      svf_pkg::MODE_HIGH: y = x - coef_mul(damping_r, v1) - v2;
      svf_pkg::MODE_BAND: y = v1;
      default:            y = v2;
    endcase
    return SBITS'(clamp(y, SBITS));
  endfunction

  function automatic void report_mismatch(input string what, input longint want,
                                          input longint got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %0d, actual %0d", $realtime, what, want, got);
  endfunction

  // input driver: new item or idle at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      sample_if.valid     <= 1'b0;
      sample_if.chan      <= 1'b0;
      sample_if.sample_in <= '0;
    end else if (!sample_if.valid || in_taken) begin
      if (pending_q.size() > 0 && int'($urandom_range(99, 0)) >= send_idle_pct) begin
        sample_if.valid     <= 1'b1;
        sample_if.chan      <= pending_q[0].chan;
        sample_if.sample_in <= pending_q[0].sample;
        void'(pending_q.pop_front());
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  // result receiver stalls at random
  always @(negedge clk) begin
    if (rst) result_if.ready <= 1'b0;
    else result_if.ready <= int'($urandom_range(99, 0)) >= recv_idle_pct;
  end

  // monitor: predict on accepted inputs, check accepted results
  always @(posedge clk) begin : monitor_blk
    svf_sample_t want;
    svf_sample_t pred;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= sample_if.valid && sample_if.ready;
      if (sample_if.valid && sample_if.ready) begin
        pred.chan   = sample_if.chan;
        pred.sample = svf_filter_step(sample_if.chan, sample_if.sample_in);
        filtered_q.insert(filtered_q.size(), pred);
      end
      if (result_if.valid && result_if.ready) begin
        if (filtered_q.size() == 0) begin
          report_mismatch("unexpected result, sample", 0, $signed(result_if.sample_out));
        end else begin
          want = filtered_q.pop_front();
          if (result_if.chan_out !== want.chan)
            report_mismatch("chan_out", want.chan, result_if.chan_out);
          if (result_if.sample_out !== want.sample)
            report_mismatch("sample_out", $signed(want.sample), $signed(result_if.sample_out));
        end
      end
    end
  end

  task automatic queue_item(input logic ch, input logic [SBITS-1:0] s);
    svf_sample_t item;
    item.chan   = ch;
    item.sample = s;
    pending_q.insert(pending_q.size(), item);
  endtask

  // block until every item is sent and every result is back
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_q.size() != 0 || sample_if.valid || filtered_q.size() != 0);
  endtask

  task automatic write_reg(input logic [svf_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [svf_pkg::COEF_BITS-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      svf_pkg::REG_FILTER_MODE: mode_r    = data[svf_pkg::MODE_BITS-1:0];
      svf_pkg::REG_COEF_A1:     a1_r      = data;
      svf_pkg::REG_COEF_A2:     a2_r      = data;
      svf_pkg::REG_COEF_A3:     a3_r      = data;
      svf_pkg::REG_DAMPING:     damping_r = data;
      default: ;
    endcase
  endtask

  // full register load plus one write to an unused index
  task automatic load_settings(input logic [svf_pkg::MODE_BITS-1:0] mode,
                               input logic [svf_pkg::COEF_BITS-1:0] a1,
                               input logic [svf_pkg::COEF_BITS-1:0] a2,
                               input logic [svf_pkg::COEF_BITS-1:0] a3,
                               input logic [svf_pkg::COEF_BITS-1:0] k);
    write_reg(svf_pkg::REG_FILTER_MODE,
              {(svf_pkg::COEF_BITS - svf_pkg::MODE_BITS)'($urandom), mode});
    write_reg(svf_pkg::REG_COEF_A1, a1);
    write_reg(svf_pkg::REG_COEF_A2, a2);
    write_reg(svf_pkg::REG_COEF_A3, a3);
    write_reg(svf_pkg::REG_DAMPING, k);
    write_reg(svf_pkg::REG_DAMPING + svf_pkg::CFG_IDX_BITS'($urandom_range(3, 1)),
              svf_pkg::COEF_BITS'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // coefficients of a stable filter from random g and k
  task automatic tuned_coefs(output logic [svf_pkg::COEF_BITS-1:0] a1,
                             output logic [svf_pkg::COEF_BITS-1:0] a2,
                             output logic [svf_pkg::COEF_BITS-1:0] a3,
                             output logic [svf_pkg::COEF_BITS-1:0] k);
    real g, kr, r1, r2, r3;
    g  = 0.005 + 1.995 * ($urandom_range(100000, 0) / 100000.0);
    kr = 0.02 + 1.98 * ($urandom_range(100000, 0) / 100000.0);
    r1 = 1.0 / (1.0 + g * (g + kr));
    r2 = g * r1;
    r3 = g * r2;
    a1 = svf_pkg::COEF_BITS'(longint'(r1 * 4194304.0));
    a2 = svf_pkg::COEF_BITS'(longint'(r2 * 4194304.0));
    a3 = svf_pkg::COEF_BITS'(longint'(r3 * 4194304.0));
    k  = svf_pkg::COEF_BITS'(longint'(kr * 4194304.0));
  endtask

  function automatic logic [SBITS-1:0] random_sample();
    case ($urandom_range(9, 0))
      5, 6, 7: return SBITS'(int'($urandom_range(8191, 0)) - 4096);
      8:       return $urandom_range(1, 0) ? {1'b0, {(SBITS-1){1'b1}}} : {1'b1, {(SBITS-1){1'b0}}};
      9:       return {SBITS{1'b0}} - SBITS'($urandom_range(2, 0));
      default: return SBITS'($urandom);
    endcase
  endfunction

  // stimulus and end of run
  initial begin : stimulus_blk
    logic [svf_pkg::COEF_BITS-1:0] a1, a2, a3, k;
    logic [svf_pkg::MODE_BITS-1:0] mode;
    int n;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    foreach (integ_one[i]) begin
      integ_one[i] = 0;
      integ_two[i] = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 74;

    // reset settings: extremes, zero, one, minus one and bit patterns on both channels
    queue_item(1'b0, {1'b0, {(SBITS-1){1'b1}}});
    queue_item(1'b0, {1'b0, {(SBITS-1){1'b1}}});
    queue_item(1'b1, {1'b1, {(SBITS-1){1'b0}}});
    queue_item(1'b1, {1'b1, {(SBITS-1){1'b0}}});
    queue_item(1'b0, '0);
    queue_item(1'b1, '1);
    queue_item(1'b0, SBITS'(1));
    queue_item(1'b1, {(SBITS/2){2'b01}});
    queue_item(1'b0, {(SBITS/2){2'b10}});
    wait_drained();

    // each response select, the spare mode code, then saturating coefficients
    tuned_coefs(a1, a2, a3, k);
    load_settings(svf_pkg::MODE_HIGH, a1, a2, a3, k);
    for (int i = 0; i < 4; i++) queue_item(i[0], random_sample());
    wait_drained();
    load_settings(svf_pkg::MODE_BAND, a1, a2, a3, k);
    for (int i = 0; i < 4; i++) queue_item(i[0], random_sample());
    wait_drained();
    load_settings(MODE_LOW_ALIAS, a1, a2, a3, k);
    for (int i = 0; i < 4; i++) queue_item(i[0], random_sample());
    wait_drained();
    load_settings(svf_pkg::MODE_HIGH, '1, '1, '1, '1);
    queue_item(1'b0, {1'b0, {(SBITS-1){1'b1}}});
    queue_item(1'b0, {1'b0, {(SBITS-1){1'b1}}});
    queue_item(1'b1, {1'b1, {(SBITS-1){1'b0}}});
    queue_item(1'b1, {1'b1, {(SBITS-1){1'b0}}});
    wait_drained();

    // random phases: idle pattern changes every four phases
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 74;
        recv_idle_pct = 28;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      mode = svf_pkg::MODE_BITS'($urandom_range(3, 0));
      case (ph % 4)
        2: begin
          a1 = svf_pkg::COEF_BITS'($urandom);
          a2 = svf_pkg::COEF_BITS'($urandom);
          a3 = svf_pkg::COEF_BITS'($urandom);
          k  = svf_pkg::COEF_BITS'($urandom);
        end
        3: begin
          a1 = ph[2] ? '0 : '1;
          a2 = a1;
          a3 = a1;
          k  = ph[2] ? '1 : '0;
          mode = ph[2] ? svf_pkg::MODE_BAND : svf_pkg::MODE_HIGH;
        end
        default: tuned_coefs(a1, a2, a3, k);
      endcase
      load_settings(mode, a1, a2, a3, k);
      n = $urandom_range(60, 40);
      for (int i = 0; i < n; i++) queue_item(1'($urandom), random_sample());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && filtered_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
